/* rtl/core/ngsc_pkg.sv */
// ----------------------------------------------------------------------------
// ngsc_pkg
// Shared types and constants of the NMEA sentence checker: line limits,
// character codes, status codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package ngsc_pkg;

  localparam int MAX_LINE   = 128;
  localparam int MAX_FIELDS = 32;

  localparam int POS_W  = $clog2(MAX_LINE);        // byte offset in a line
  localparam int FIDX_W = $clog2(MAX_FIELDS);      // field table address
  localparam int FCNT_W = $clog2(MAX_FIELDS + 1);  // field count, holds MAX_FIELDS

  localparam logic [POS_W-1:0]  LAST_POS     = POS_W'(MAX_LINE - 1);
  localparam logic [FCNT_W-1:0] FIELDS_LIMIT = FCNT_W'(MAX_FIELDS);

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] STAR_BYTE    = 8'd42;
  localparam logic [7:0] COMMA_BYTE   = 8'd44;

  localparam logic [23:0] SENTENCE_TYPE_RESET = 24'h474741;  // "GGA"

  typedef enum logic [2:0] {
    ST_FIELD      = 3'd0,
    ST_WRONG_TYPE = 3'd1,
    ST_NO_STAR    = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_RUN,   // taking bytes
    S_STAT,  // one status item waits for the output register
    S_RD,    // field table read in flight
    S_EMIT   // descriptor waits for the output register
  } ctrl_state_t;

  typedef struct packed {
    logic take_byte;  // a byte transaction completes this cycle
    logic load_stat;  // load line status item into the output register
    logic load_desc;  // load a field descriptor into the output register
    logic idx_clr;
    logic idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic is_newline;  // byte on the input is a newline
    logic emit_desc;   // the line ending now passes and has fields
    logic out_free;    // output register can take a result this cycle
    logic drain_last;  // descriptor index is the line's last field
  } dp_stat_t;

  // {invalid, value} of an uppercase hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b0, 4'(c - 8'd48)};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      r = {1'b0, 4'(c - 8'd55)};
    end else begin
      r = 5'b10000;
    end
    return r;
  endfunction

endpackage

/* rtl/core/ngsc_ctrl.sv */
// ----------------------------------------------------------------------------
// ngsc_ctrl
// Controller: byte intake, then per line end either one status item or a
// drain of the field table, each descriptor read (S_RD) before it is loaded.
// ----------------------------------------------------------------------------
module ngsc_ctrl
  import ngsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (in_valid && stat.is_newline) begin
          state_nxt = stat.emit_desc ? S_RD : S_STAT;
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          state_nxt = S_RUN;
        end
      end
      S_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.drain_last ? S_RUN : S_RD;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_RUN: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
        cmd.idx_clr   = in_valid && stat.is_newline;
      end
      S_STAT: begin
        cmd.load_stat = stat.out_free;
      end
      S_RD: begin
        cmd = '0;
      end
      S_EMIT: begin
        cmd.load_desc = stat.out_free;
        cmd.idx_inc   = stat.out_free && !stat.drain_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/ngsc_dp.sv */
// ----------------------------------------------------------------------------
// ngsc_dp
// Datapath: per-line checksum, type and field tracking, field table memory,
// line-end status capture and the output register.
// ----------------------------------------------------------------------------
module ngsc_dp
  import ngsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [23:0] cfg_sentence_type,
  input  logic [7:0] in_data_byte,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [4:0] out_field_index,
  output logic [6:0] out_field_start,
  output logic [6:0] out_field_length,
  output logic       out_last,
  input  dp_cmd_t    cmd,
  output dp_stat_t   stat
);

  logic [23:0]       stype_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        xsum_r, xsum_nxt;
  logic              star_r, star_nxt;
  logic [1:0]        hex_cnt_r, hex_cnt_nxt;
  logic [7:0]        rsum_r, rsum_nxt;
  logic              hex_bad_r, hex_bad_nxt;
  logic              tmatch_r, tmatch_nxt;
  logic              ovf_r, ovf_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [POS_W-1:0]  fstart_r, fstart_nxt;

  logic [2*POS_W-1:0] ftab [MAX_FIELDS];
  logic [2*POS_W-1:0] rd_data_r;
  logic               wr_en;
  logic [FIDX_W-1:0]  wr_addr;
  logic [2*POS_W-1:0] wr_data;

  status_t           line_st_r, st_now, st_final;
  logic [FIDX_W-1:0] last_idx_r, drain_idx_r;

  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [4:0] out_index_r;
  logic [6:0] out_start_r, out_length_r;
  logic       out_last_r;

  logic       is_nl;
  logic [7:0] want;
  logic [4:0] hex;

  assign is_nl = (in_data_byte == NEWLINE_BYTE);
  assign hex   = hex_nibble(in_data_byte);

  always_comb begin
    case (pos_r)
      POS_W'(3): want = stype_r[23:16];
      POS_W'(4): want = stype_r[15:8];
      default:   want = stype_r[7:0];
    endcase
  end

  // line status as seen at a newline
  always_comb begin
    if (ovf_r) begin
      st_now = ST_TOO_LONG;
    end else if (!tmatch_r || pos_r < POS_W'(6)) begin
      st_now = ST_WRONG_TYPE;
    end else if (!star_r) begin
      st_now = ST_NO_STAR;
    end else if (hex_bad_r || hex_cnt_r < 2'd2 || rsum_r != xsum_r) begin
      st_now = ST_BAD_SUM;
    end else begin
      st_now = ST_FIELD;
    end
    st_final = (st_now == ST_FIELD && fcnt_r == '0) ? ST_NO_STAR : st_now;
  end

  // per-byte update
  always_comb begin
    pos_nxt     = pos_r;
    xsum_nxt    = xsum_r;
    star_nxt    = star_r;
    hex_cnt_nxt = hex_cnt_r;
    rsum_nxt    = rsum_r;
    hex_bad_nxt = hex_bad_r;
    tmatch_nxt  = tmatch_r;
    ovf_nxt     = ovf_r;
    fcnt_nxt    = fcnt_r;
    fstart_nxt  = fstart_r;
    wr_en       = 1'b0;
    wr_addr     = fcnt_r[FIDX_W-1:0];
    wr_data     = {fstart_r, POS_W'(pos_r - fstart_r)};
    if (cmd.take_byte) begin
      if (is_nl) begin
        pos_nxt     = '0;
        xsum_nxt    = '0;
        star_nxt    = 1'b0;
        hex_cnt_nxt = '0;
        rsum_nxt    = '0;
        hex_bad_nxt = 1'b0;
        tmatch_nxt  = 1'b1;
        ovf_nxt     = 1'b0;
        fcnt_nxt    = '0;
        fstart_nxt  = POS_W'(1);
      end else if (pos_r == LAST_POS) begin
        ovf_nxt = 1'b1;  // byte dropped
      end else begin
        if (pos_r >= POS_W'(3) && pos_r <= POS_W'(5) && in_data_byte != want) begin
          tmatch_nxt = 1'b0;
        end
        if (pos_r != '0) begin
          if (!star_r) begin
            if (in_data_byte == STAR_BYTE) begin
              star_nxt = 1'b1;
              wr_en    = (fcnt_r < FIELDS_LIMIT);
            end else begin
              xsum_nxt = xsum_r ^ in_data_byte;
              if (in_data_byte == COMMA_BYTE) begin
                wr_en      = (fcnt_r < FIELDS_LIMIT);
                fstart_nxt = POS_W'(pos_r + POS_W'(1));
              end
            end
          end else if (hex_cnt_r < 2'd2) begin
            if (hex[4]) begin
              hex_bad_nxt = 1'b1;
            end else begin
              rsum_nxt = {rsum_r[3:0], hex[3:0]};
            end
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
        if (wr_en) begin
          fcnt_nxt = fcnt_r + FCNT_W'(1);
        end
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stype_r   <= SENTENCE_TYPE_RESET;
      pos_r     <= '0;
      xsum_r    <= '0;
      star_r    <= 1'b0;
      hex_cnt_r <= '0;
      rsum_r    <= '0;
      hex_bad_r <= 1'b0;
      tmatch_r  <= 1'b1;
      ovf_r     <= 1'b0;
      fcnt_r    <= '0;
      fstart_r  <= POS_W'(1);
    end else begin
      if (cfg_valid) begin
        stype_r <= cfg_sentence_type;
      end
      pos_r     <= pos_nxt;
      xsum_r    <= xsum_nxt;
      star_r    <= star_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      rsum_r    <= rsum_nxt;
      hex_bad_r <= hex_bad_nxt;
      tmatch_r  <= tmatch_nxt;
      ovf_r     <= ovf_nxt;
      fcnt_r    <= fcnt_nxt;
      fstart_r  <= fstart_nxt;
    end
  end

  // field table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ftab[wr_addr] <= wr_data;
    end
    rd_data_r <= ftab[drain_idx_r];
  end

  // line end capture
  always_ff @(posedge clk) begin
    if (cmd.take_byte && is_nl) begin
      line_st_r  <= st_final;
      last_idx_r <= FIDX_W'(fcnt_r - FCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_idx_r <= '0;
    end else if (cmd.idx_clr) begin
      drain_idx_r <= '0;
    end else if (cmd.idx_inc) begin
      drain_idx_r <= drain_idx_r + FIDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_stat || cmd.load_desc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      out_status_r <= line_st_r;
      out_index_r  <= '0;
      out_start_r  <= '0;
      out_length_r <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_desc) begin
      out_status_r <= ST_FIELD;
      out_index_r  <= 5'(drain_idx_r);
      out_start_r  <= 7'(rd_data_r[2*POS_W-1:POS_W]);
      out_length_r <= 7'(rd_data_r[POS_W-1:0]);
      out_last_r   <= (drain_idx_r == last_idx_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_field_index  = out_index_r;
  assign out_field_start  = out_start_r;
  assign out_field_length = out_length_r;
  assign out_last         = out_last_r;

  assign stat.is_newline = is_nl;
  assign stat.emit_desc  = (st_now == ST_FIELD) && (fcnt_r != '0);
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.drain_last = (drain_idx_r == last_idx_r);

endmodule

/* rtl/core/nmea_gga_sentence_checker.sv */
// ----------------------------------------------------------------------------
// nmea_gga_sentence_checker
// NMEA line checker: sentence type match, XOR checksum against the hex
// digits after '*', and comma field indexing with per-field descriptors.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while a line is received; no output then.
// Newline: input stalls until the line's results are in the output register:
//   a status item is loaded in S_STAT, each descriptor is read from the
//   field table in S_RD and loaded in S_EMIT, each load waiting for a
//   free output register.
// Reset: synchronous, active low; sentence type returns to "GGA".
module nmea_gga_sentence_checker
  import ngsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_sentence_type,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [4:0]  out_field_index,
  output logic [6:0]  out_field_start,
  output logic [6:0]  out_field_length,
  output logic        out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // cfg_ready is tied high; software only writes while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  // Controller: sequences byte intake and the descriptor drain.
  ngsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: line state, field table, output register.
  ngsc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_sentence_type (cfg_sentence_type),
    .in_data_byte      (in_data_byte),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_field_index   (out_field_index),
    .out_field_start   (out_field_start),
    .out_field_length  (out_field_length),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

  // A newline transaction must freeze intake so the field table is kept
  // for the drain.
  a_nl_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data_byte == NEWLINE_BYTE) |=> in_stall)
    else $error("input not stalled after newline");

  // Status items are always the single, final result of their line.
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_status == ST_FIELD))
    else $error("non-final result is not a field descriptor");

  // Status items carry zero index, start and length.
  a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_FIELD) |->
      (out_field_index == '0 && out_field_start == '0 && out_field_length == '0))
    else $error("status item with nonzero field data");

  // Results only appear while the input side is held.
  a_out_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while taking bytes");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: NMEA GGA sentence checker testbench
// Feeds NMEA lines byte by byte into the sentence checker. A line-level
// predictor in this module tracks type match, XOR sum, hex digits and the
// comma field table, and queues the status item or field descriptors that
// each newline must produce. Output transactions are compared in order,
// field by field. The sentence type register is rewritten between phases,
// only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ngsc_pkg::*;

  // one output transaction: a field descriptor or a line status item
  typedef struct packed {
    status_t     status;
    logic [4:0]  fidx;
    logic [6:0]  fstart;
    logic [6:0]  flen;
    logic        last;
  } field_report_t;

  // shapes of generated sentences
  typedef enum {
    LN_GOOD,       // correct sentence
    LN_BAD_SUM,    // checksum digits do not match
    LN_BAD_HEX,    // a non-hex byte among the checksum digits
    LN_SHORT_HEX,  // one checksum digit only
    LN_NO_STAR,    // no '*' at all
    LN_BAD_TYPE,   // one type character altered
    LN_TRAILER     // correct, with commas and junk after the digits
  } line_kind_t;

  localparam logic [23:0] GGA_TYPE      = SENTENCE_TYPE_RESET;
  localparam logic [23:0] RMC_TYPE      = 24'h524D43;
  localparam logic [7:0]  CR_BYTE       = 8'd13;
  localparam logic [7:0]  DOLLAR_BYTE   = 8'h24;
  localparam int          SETTLE_CYCLES = 8;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_sentence_type = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [4:0]  out_field_index;
  logic [6:0]  out_field_start;
  logic [6:0]  out_field_length;
  logic        out_last;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmea_gga_sentence_checker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sentence_type (cfg_sentence_type),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_field_index   (out_field_index),
    .out_field_start   (out_field_start),
    .out_field_length  (out_field_length),
    .out_last          (out_last)
  );

  // --------------------------------------------------------------------------
  // Bookkeeping
  // --------------------------------------------------------------------------
  logic [7:0]    byte_fifo[$];        // bytes waiting for the driver
  field_report_t pending_results[$];  // predicted output transactions, oldest first
  int            bytes_queued = 0;
  int            bytes_taken = 0;
  int            lines_queued = 0;
  int            random_lines = 0;
  int            results_checked = 0;
  int            errors = 0;
  bit            calm = 1'b0;         // set for the tail of the run: no idling
  bit            idle_on = 1'b1;      // toggles to give stretches without idling
  bit            in_taken = 1'b0;     // byte transaction completed at last edge
  int            gap_left = 0;
  int            stall_left = 0;

  // --------------------------------------------------------------------------
  // Line predictor state. Mirrors the per-line registers of the block; the
  // sentence type copy changes only on a completed config transaction.
  // --------------------------------------------------------------------------
  logic [23:0] type_cfg = GGA_TYPE;
  logic [6:0]  line_pos = '0;
  logic [7:0]  run_xor = '0;
  bit          star_hit = 1'b0;
  logic [1:0]  digits_in = '0;
  logic [7:0]  sum_rx = '0;
  bit          digit_bad = 1'b0;
  bit          type_ok = 1'b1;
  bit          too_long = 1'b0;
  logic [5:0]  n_fields = '0;
  logic [6:0]  open_start = 7'd1;
  logic [6:0]  start_tab[MAX_FIELDS];
  logic [6:0]  len_tab[MAX_FIELDS];

  // Record the field that ends at offset end_pos, if the table has room.
  function automatic void close_field(input logic [6:0] end_pos);
    if (n_fields < MAX_FIELDS) begin
      start_tab[n_fields] = open_start;
      len_tab[n_fields]   = end_pos - open_start;
      n_fields++;
    end
  endfunction

  // Advance the predictor by one accepted byte; a newline queues its results.
  function automatic void predict_line_byte(input logic [7:0] c);
    logic [6:0]    p;
    status_t       st;
    field_report_t r;
    int            shift;
    p = line_pos;
    if (c == NEWLINE_BYTE) begin
      // priority: too long, wrong type (short lines too), no star, bad sum
      if (too_long) begin
        st = ST_TOO_LONG;
      end else if (!type_ok || p < 7'd6) begin
        st = ST_WRONG_TYPE;
      end else if (!star_hit) begin
        st = ST_NO_STAR;
      end else if (digit_bad || digits_in < 2'd2 || sum_rx != run_xor) begin
        st = ST_BAD_SUM;
      end else begin
        st = ST_FIELD;
      end
      if (st == ST_FIELD && n_fields != 0) begin
        for (int k = 0; k < n_fields; k++) begin
          r.status = ST_FIELD;
          r.fidx   = 5'(k);
          r.fstart = start_tab[k];
          r.flen   = len_tab[k];
          r.last   = (k + 1 == n_fields);
          pending_results.push_back(r);
        end
      end else begin
        r.status = (st == ST_FIELD) ? ST_NO_STAR : st;
        r.fidx   = '0;
        r.fstart = '0;
        r.flen   = '0;
        r.last   = 1'b1;
        pending_results.push_back(r);
      end
      // per-line state back to its reset values
      line_pos   = '0;
      run_xor    = '0;
      star_hit   = 1'b0;
      digits_in  = '0;
      sum_rx     = '0;
      digit_bad  = 1'b0;
      type_ok    = 1'b1;
      too_long   = 1'b0;
      n_fields   = '0;
      open_start = 7'd1;
      return;
    end

    // the last line offset is never stored; such a line is over-long
    if (p == LAST_POS) begin
      too_long = 1'b1;
      return;
    end

    if (p >= 7'd3 && p <= 7'd5) begin
      shift = 8 * (5 - int'(p));
      if (c != type_cfg[shift +: 8]) type_ok = 1'b0;
    end

    // offset 0 is neither summed nor a delimiter
    if (p != 7'd0) begin
      if (!star_hit) begin
        if (c == STAR_BYTE) begin
          close_field(p);
          star_hit = 1'b1;
        end else begin
          run_xor = run_xor ^ c;
          if (c == COMMA_BYTE) begin
            close_field(p);
            open_start = p + 7'd1;
          end
        end
      end else if (digits_in < 2'd2) begin
        // uppercase hex only; later bytes are ignored
        if (c >= 8'd48 && c <= 8'd57) begin
          sum_rx = {sum_rx[3:0], 4'(c - 8'd48)};
        end else if (c >= 8'd65 && c <= 8'd70) begin
          sum_rx = {sum_rx[3:0], 4'(c - 8'd55)};
        end else begin
          digit_bad = 1'b1;
        end
        digits_in++;
      end
    end
    line_pos = p + 7'd1;
  endfunction

  // --------------------------------------------------------------------------
  // Line builders: each appends one complete line, newline included.
  // --------------------------------------------------------------------------
  function automatic void post_line(input logic [7:0] ln[$]);
    foreach (ln[i]) byte_fifo.push_back(ln[i]);
    bytes_queued += ln.size();
    lines_queued++;
  endfunction

  function automatic logic [7:0] to_hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? 8'd48 + 8'(v) : 8'd55 + 8'(v);
  endfunction

  // Field content: any byte but newline, '*' and ','; bit 7 included.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == NEWLINE_BYTE || c == STAR_BYTE || c == COMMA_BYTE);
    return c;
  endfunction

  // A byte that is not an uppercase hex digit, often a lowercase one.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) return 8'd97 + 8'($urandom_range(0, 5));
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == NEWLINE_BYTE || (c >= 8'd48 && c <= 8'd57) ||
               (c >= 8'd65 && c <= 8'd70));
    return c;
  endfunction

  function automatic void queue_text(input string s);
    logic [7:0] ln[$];
    for (int i = 0; i < s.len(); i++) ln.push_back(s[i]);
    ln.push_back(NEWLINE_BYTE);
    post_line(ln);
  endfunction

  function automatic void queue_noise(input int n);
    logic [7:0] ln[$];
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == NEWLINE_BYTE);
      ln.push_back(c);
    end
    ln.push_back(NEWLINE_BYTE);
    post_line(ln);
  endfunction

  // lead + "GP" + type + nf comma fields of lmin..lmax bytes + '*' + two digits, varied by kind
  function automatic void queue_sentence(input logic [7:0] lead, input logic [23:0] ty,
                                         input int nf, input int lmin, input int lmax,
                                         input line_kind_t kind, input bit cr);
    logic [7:0] ln[$];
    logic [7:0] sum;
    int         n;
    ln.push_back(lead);
    ln.push_back("G");
    ln.push_back("P");
    for (int i = 2; i >= 0; i--) ln.push_back(ty[8*i +: 8]);
    if (kind == LN_BAD_TYPE) ln[3 + $urandom_range(0, 2)] ^= 8'h80;
    for (int k = 0; k < nf; k++) begin
      ln.push_back(COMMA_BYTE);
      n = $urandom_range(lmin, lmax);
      for (int j = 0; j < n; j++) ln.push_back(field_char());
    end
    sum = '0;
    for (int i = 1; i < ln.size(); i++) sum ^= ln[i];
    if (kind != LN_NO_STAR) begin
      ln.push_back(STAR_BYTE);
      if (kind == LN_BAD_SUM) sum ^= 8'($urandom_range(1, 255));
      ln.push_back(to_hex_digit(sum[7:4]));
      if (kind != LN_SHORT_HEX) ln.push_back(to_hex_digit(sum[3:0]));
      if (kind == LN_BAD_HEX) ln[ln.size() - 1 - $urandom_range(0, 1)] = non_hex_char();
      if (kind == LN_TRAILER) begin
        ln.push_back(COMMA_BYTE);
        ln.push_back(STAR_BYTE);
        ln.push_back(COMMA_BYTE);
        ln.push_back(field_char());
      end
    end
    if (cr) ln.push_back(CR_BYTE);
    ln.push_back(NEWLINE_BYTE);
    post_line(ln);
  endfunction

  // Mostly well-formed sentences with random content; some broken, some noise.
  function automatic void queue_random_line();
    int          pick;
    line_kind_t  kind;
    logic [7:0]  lead;
    logic [23:0] ty;
    int          nf;
    int          lmin;
    int          lmax;
    random_lines++;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      queue_noise($urandom_range(0, 24));
      return;
    end
    if (pick < 12) begin
      queue_noise($urandom_range(0, 6));  // short line of at most six bytes
      return;
    end
    kind = (pick < 62) ? LN_GOOD :
           (pick < 69) ? LN_BAD_SUM :
           (pick < 75) ? LN_BAD_HEX :
           (pick < 81) ? LN_SHORT_HEX :
           (pick < 87) ? LN_NO_STAR :
           (pick < 93) ? LN_BAD_TYPE : LN_TRAILER;
    lead = DOLLAR_BYTE;
    if ($urandom_range(0, 9) == 0) begin
      do lead = 8'($urandom_range(0, 255)); while (lead == NEWLINE_BYTE);
    end
    ty = ($urandom_range(0, 7) == 0) ? 24'($urandom()) : type_cfg;
    nf = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 36) : $urandom_range(0, 4);
    lmin = 0;
    lmax = ($urandom_range(0, 9) == 0) ? 20 : 3;
    if ($urandom_range(0, 29) == 0) begin
      // a few lines near the length limit
      nf   = 1;
      lmin = 110;
      lmax = 119;
    end
    queue_sentence(lead, ty, nf, lmin, lmax, kind, $urandom_range(0, 1));
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: next byte goes out at the falling edge once the previous
  // transaction has completed; random gaps in between while idling is on and not calm.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) idle_on <= !idle_on;
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (byte_fifo.size() != 0) begin
        in_valid     <= 1'b1;
        in_data_byte <= byte_fifo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in random bursts, started only while idling is on and not calm.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: byte transactions feed the predictor, result transactions are
  // checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    field_report_t exp_r;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      bytes_taken++;
      predict_line_byte(in_data_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: status %0d index %0d",
               out_status, out_field_index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          errors++;
        end
        if (out_field_index !== exp_r.fidx) begin
          $error("field_index: expected %0d, got %0d", exp_r.fidx, out_field_index);
          errors++;
        end
        if (out_field_start !== exp_r.fstart) begin
          $error("field_start: expected %0d, got %0d", exp_r.fstart, out_field_start);
          errors++;
        end
        if (out_field_length !== exp_r.flen) begin
          $error("field_length: expected %0d, got %0d", exp_r.flen, out_field_length);
          errors++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------

  // Hold off until every queued byte is taken and every result has arrived,
  // then give the block its latency before anything else happens.
  task automatic settle();
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_sentence_type(input logic [23:0] value);
    cfg_valid         <= 1'b1;
    cfg_sentence_type <= value;
    do @(posedge clk); while (!cfg_ready);
    type_cfg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int random_base;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed lines under the reset type
    queue_text("");                                   // empty line
    queue_text("$GPGG");                              // ends before offset 6
    queue_sentence(DOLLAR_BYTE, GGA_TYPE, 2, 0, 2, LN_GOOD, 1'b1);
    queue_sentence(DOLLAR_BYTE, GGA_TYPE, 1, 1, 1, LN_BAD_HEX, 1'b0);
    queue_sentence(DOLLAR_BYTE, GGA_TYPE, 1, 1, 1, LN_SHORT_HEX, 1'b0);
    // '*' at offset 0 must not act as a delimiter
    queue_sentence(STAR_BYTE, GGA_TYPE, 1, 0, 1, LN_GOOD, 1'b0);
    queue_sentence(DOLLAR_BYTE, GGA_TYPE, 1, 0, 1, LN_TRAILER, 1'b0);
    // field table over-full: only the first fields are reported
    queue_sentence(DOLLAR_BYTE, GGA_TYPE, 33, 0, 0, LN_GOOD, 1'b0);
    // one byte past the line limit, with wrong type and no star as well
    queue_sentence(DOLLAR_BYTE, RMC_TYPE, 1, 121, 121, LN_NO_STAR, 1'b0);
    settle();

    random_base = bytes_queued;

    // all-ones type
    write_sentence_type(24'hFFFFFF);
    queue_sentence(DOLLAR_BYTE, 24'hFFFFFF, 1, 0, 1, LN_GOOD, 1'b0);
    while (bytes_queued - random_base < 12) queue_random_line();
    settle();

    // all-zeros type
    write_sentence_type(24'h000000);
    queue_sentence(DOLLAR_BYTE, 24'h000000, 1, 0, 1, LN_GOOD, 1'b1);
    while (bytes_queued - random_base < 24) queue_random_line();
    settle();

    write_sentence_type(RMC_TYPE);
    while (bytes_queued - random_base < 32) queue_random_line();
    settle();

    write_sentence_type(GGA_TYPE);
    while (bytes_queued - random_base < 40) queue_random_line();
    settle();

    // tail of the run at full rate on both sides
    calm = 1'b1;
    while (bytes_queued - random_base < 52 || random_lines < 6) queue_random_line();
    settle();

    $display("Run covered %0d lines, %0d bytes and %0d result transactions", lines_queued,
             bytes_taken, results_checked);
    $display("under four sentence types, including all-zero and all-one settings.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
